// ===== rtl/cdds_pkg.sv =====
// Package for the civil date day shift block: calendar constants, reciprocal
// constants for the constant divisions, the month start table and stage types.
// No dependencies.
package cdds_pkg;

    localparam int MAX_YEAR   = 9999;
    localparam int ERA_DAYS   = 146097;
    localparam int CENT_DAYS  = 36524;
    localparam int QUAD_DAYS  = 1461;
    localparam int YEAR_DAYS  = 365;
    localparam int DAY_SECS   = 86400;
    localparam int LOW_COUNT  = -59;
    localparam int MAX_U      = MAX_YEAR + 400;
    localparam int HIGH_COUNT = 365 * MAX_U + MAX_U / 4 - MAX_U / 100 + MAX_U / 400
                                - ERA_DAYS + 306;

    // Reciprocals for division by constants; shifts are in the slice positions.
    localparam int REC_CENT   = 5243;     // /100, shift 19, exact for u < 10400
    localparam int REC_MIN    = 139811;   // /60, shift 23, exact below 86400
    localparam int REC_HOUR   = 1093;     // /60, shift 16, exact below 1440
    localparam int REC_ERA    = 29398;    // /146097, shift 32, may be one low
    localparam int REC_QUAD   = 1435;     // /1461, shift 21, may be one low

    localparam int NUM_STAGES = 13;

    function automatic logic [8:0] month_base(input logic [3:0] idx);
        logic [8:0] res;
        unique case (idx)
            4'd0:    res = 9'd0;
            4'd1:    res = 9'd31;
            4'd2:    res = 9'd61;
            4'd3:    res = 9'd92;
            4'd4:    res = 9'd122;
            4'd5:    res = 9'd153;
            4'd6:    res = 9'd184;
            4'd7:    res = 9'd214;
            4'd8:    res = 9'd245;
            4'd9:    res = 9'd275;
            4'd10:   res = 9'd306;
            4'd11:   res = 9'd337;
            default: res = 9'd0;
        endcase
        return res;
    endfunction

    typedef struct packed {
        logic [22:0] src;
        logic [22:0] shc;
        logic        bad;
        logic [4:0]  hr;
        logic [5:0]  mn;
        logic [5:0]  ss;
    } t_tail;

    typedef struct packed {
        logic [13:0] u;
        logic [8:0]  mb;
        logic [4:0]  day;
        logic [16:0] secs;
        logic        carry;
        logic [22:0] off;
    } t_st1;

    typedef struct packed {
        logic [6:0]  c;
        logic [13:0] u;
        logic [8:0]  mb;
        logic [5:0]  dc;
        logic [16:0] secs;
        logic [10:0] q;
        logic [22:0] off;
    } t_st2;

    typedef struct packed {
        logic [6:0]  yy;
        logic [22:0] p1;
        logic [5:0]  ss;
        logic [4:0]  hr;
        logic [10:0] q;
        logic [22:0] off;
    } t_st3;

    typedef struct packed {
        logic [22:0] src;
        logic [4:0]  hr;
        logic [5:0]  mn;
        logic [5:0]  ss;
        logic [22:0] off;
    } t_st4;

    typedef struct packed {
        logic [21:0] d;
        t_tail       tl;
    } t_st5;

    typedef struct packed {
        logic [4:0]  era;
        logic [21:0] d;
        t_tail       tl;
    } t_st6;

    typedef struct packed {
        logic [4:0]  era;
        logic [18:0] rem;
        t_tail       tl;
    } t_st7;

    typedef struct packed {
        logic [4:0]  era;
        logic [1:0]  c2;
        logic [15:0] doc;
        t_tail       tl;
    } t_st8;

    typedef struct packed {
        logic [4:0]  era;
        logic [1:0]  c2;
        logic [4:0]  q4;
        logic [15:0] doc;
        t_tail       tl;
    } t_st9;

    typedef struct packed {
        logic [4:0]  era;
        logic [1:0]  c2;
        logic [4:0]  q4;
        logic [11:0] r4;
        t_tail       tl;
    } t_st10;

    typedef struct packed {
        logic [4:0]  era;
        logic [8:0]  yoe;
        logic [8:0]  doy;
        t_tail       tl;
    } t_st11;

    typedef struct packed {
        logic [13:0] y;
        logic [3:0]  mp;
        logic [4:0]  rd;
        t_tail       tl;
    } t_st12;

    typedef struct packed {
        logic [13:0] yr;
        logic [3:0]  mo;
        logic [4:0]  dy;
        t_tail       tl;
    } t_res;

endpackage

// ===== rtl/civil_date_day_shift.sv =====
// Civil date day shift: top level, a thirteen stage pipeline that converts a date to a
// March-based day count, adds a signed day offset and converts the result back.
// Depends on cdds_pkg.
//
// One transfer is taken in every clock cycle when the output side is not stalled; the
// depth is set by the chain of constant divisions (century, era, quadrennium) that each
// get a multiply stage; the era and quadrennium divisions also get a correction stage.
// Stages hold valid bits of their own, so an empty stage further down lets a new
// transfer in while a finished result waits.
// Results outside years 0 to 9999 raise tuser and give zero year, month and day.
module civil_date_day_shift (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // src_year[13:0], src_month[17:14], src_day[22:18], src_hour[27:23],
    // src_minute[33:28], src_second[39:34], day_offset[62:40], zero[63]
    input  logic [63:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // source_day_count[22:0], shifted_day_count[45:23], res_year[59:46],
    // res_month[63:60], res_day[68:64], res_hour[73:69], res_minute[79:74],
    // res_second[85:80], zero[87:86]
    output logic [87:0] m_axis_tdata,
    // out_of_range[0]
    output logic [0:0]  m_axis_tuser
);
    import cdds_pkg::*;

    localparam int NS = NUM_STAGES;
    localparam logic signed [23:0] LOW24  = 24'(LOW_COUNT);
    localparam logic signed [23:0] HIGH24 = 24'(HIGH_COUNT);

    logic [NS-1:0] r_v, n_v, adv;

    t_st1  r_s1, n_s1;
    t_st2  r_s2, n_s2;
    t_st3  r_s3, n_s3;
    t_st4  r_s4, n_s4;
    t_st5  r_s5, n_s5;
    t_st6  r_s6, n_s6;
    t_st7  r_s7, n_s7;
    t_st8  r_s8, n_s8;
    t_st9  r_s9, n_s9;
    t_st10 r_s10, n_s10;
    t_st11 r_s11, n_s11;
    t_st12 r_s12, n_s12;
    t_res  r_out, n_out;

    // A stage may load when it or any stage after it is empty, or the output is taken.
    always_comb begin
        for (int i = 0; i < NS; i++) begin
            adv[i] = m_axis_tready || ((~r_v >> i) != '0);
        end
        n_v[0] = adv[0] ? s_axis_tvalid : r_v[0];
        for (int i = 1; i < NS; i++) begin
            n_v[i] = adv[i] ? r_v[i-1] : r_v[i];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            r_v <= n_v;
        end
    end

    // Stage 1: clamp fields, move January and February to the prior year, total seconds.
    always_comb begin
        logic [13:0] y_in;
        logic [3:0]  m_cl;
        logic [3:0]  mi;
        logic        lt3;
        logic [16:0] s_sum;
        y_in = s_axis_tdata[13:0];
        if (y_in > 14'(MAX_YEAR)) begin
            y_in = 14'(MAX_YEAR);
        end
        m_cl = s_axis_tdata[17:14];
        if (m_cl == 4'd0) begin
            m_cl = 4'd1;
        end else if (m_cl > 4'd12) begin
            m_cl = 4'd12;
        end
        lt3 = m_cl < 4'd3;
        mi = lt3 ? m_cl + 4'd9 : m_cl - 4'd3;
        s_sum = 17'(s_axis_tdata[27:23]) * 17'd3600 + 17'(s_axis_tdata[33:28]) * 17'd60
                + 17'(s_axis_tdata[39:34]);
        n_s1.u     = y_in + (lt3 ? 14'd399 : 14'd400);
        n_s1.mb    = month_base(mi);
        n_s1.day   = s_axis_tdata[22:18];
        n_s1.carry = s_sum >= 17'(DAY_SECS);
        n_s1.secs  = n_s1.carry ? s_sum - 17'(DAY_SECS) : s_sum;
        n_s1.off   = s_axis_tdata[62:40];
    end

    // Stage 2: century of the shifted year and whole minutes of the day.
    always_comb begin
        logic [25:0] pc;
        logic [34:0] pm;
        pc = 26'(r_s1.u) * 26'(REC_CENT);
        pm = 35'(r_s1.secs) * 35'(REC_MIN);
        n_s2.c    = pc[25:19];
        n_s2.u    = r_s1.u;
        n_s2.mb   = r_s1.mb;
        n_s2.dc   = 6'(r_s1.day) + 6'(r_s1.carry);
        n_s2.secs = r_s1.secs;
        n_s2.q    = pm[33:23];
        n_s2.off  = r_s1.off;
    end

    // Stage 3: year within the century, century part of the count, seconds and hours.
    always_comb begin
        logic [13:0] yy_w;
        logic [16:0] ss_w;
        logic [21:0] ph;
        yy_w = r_s2.u - 14'(r_s2.c) * 14'd100;
        ss_w = r_s2.secs - 17'(r_s2.q) * 17'd60;
        ph   = 22'(r_s2.q) * 22'(REC_HOUR);
        n_s3.yy  = yy_w[6:0];
        n_s3.p1  = 23'(r_s2.c) * 23'(CENT_DAYS) + 23'(r_s2.c >> 2) + 23'(r_s2.mb)
                   + 23'(r_s2.dc) - 23'(ERA_DAYS);
        n_s3.ss  = ss_w[5:0];
        n_s3.hr  = ph[20:16];
        n_s3.q   = r_s2.q;
        n_s3.off = r_s2.off;
    end

    // Stage 4: day count of the source date and minutes of the hour.
    always_comb begin
        logic [10:0] mn_w;
        mn_w = r_s3.q - 11'(r_s3.hr) * 11'd60;
        n_s4.src = r_s3.p1 + 23'(r_s3.yy) * 23'(YEAR_DAYS) + 23'(r_s3.yy >> 2);
        n_s4.hr  = r_s3.hr;
        n_s4.mn  = mn_w[5:0];
        n_s4.ss  = r_s3.ss;
        n_s4.off = r_s3.off;
    end

    // Stage 5: add the offset, saturate, and move the count into one positive era.
    always_comb begin
        logic signed [23:0] sum;
        logic [23:0]        dw;
        logic               lo, hi;
        sum = $signed({r_s4.src[22], r_s4.src}) + $signed({r_s4.off[22], r_s4.off});
        lo  = sum < LOW24;
        hi  = sum > HIGH24;
        dw  = sum + 24'(ERA_DAYS - 1);
        n_s5.d      = dw[21:0];
        n_s5.tl.src = r_s4.src;
        n_s5.tl.shc = lo ? LOW24[22:0] : (hi ? HIGH24[22:0] : sum[22:0]);
        n_s5.tl.bad = lo || hi;
        n_s5.tl.hr  = r_s4.hr;
        n_s5.tl.mn  = r_s4.mn;
        n_s5.tl.ss  = r_s4.ss;
    end

    // Stage 6: era estimate.
    always_comb begin
        logic [36:0] pe;
        pe = 37'(r_s5.d) * 37'(REC_ERA);
        n_s6.era = pe[36:32];
        n_s6.d   = r_s5.d;
        n_s6.tl  = r_s5.tl;
    end

    // Stage 7: remainder against the era estimate.
    always_comb begin
        logic [21:0] rw;
        rw = r_s6.d - 22'(r_s6.era) * 22'(ERA_DAYS);
        n_s7.era = r_s6.era;
        n_s7.rem = rw[18:0];
        n_s7.tl  = r_s6.tl;
    end

    // Stage 8: correct the era, then split the day of era into centuries.
    always_comb begin
        logic        ge;
        logic [18:0] dw;
        logic [17:0] doe;
        logic [17:0] dcw;
        logic [1:0]  c2;
        ge  = r_s7.rem >= 19'(ERA_DAYS);
        dw  = ge ? r_s7.rem - 19'(ERA_DAYS) : r_s7.rem;
        doe = dw[17:0];
        if (doe >= 18'(3 * CENT_DAYS)) begin
            c2 = 2'd3;
        end else if (doe >= 18'(2 * CENT_DAYS)) begin
            c2 = 2'd2;
        end else if (doe >= 18'(CENT_DAYS)) begin
            c2 = 2'd1;
        end else begin
            c2 = 2'd0;
        end
        dcw = doe - 18'(c2) * 18'(CENT_DAYS);
        n_s8.era = r_s7.era + 5'(ge);
        n_s8.c2  = c2;
        n_s8.doc = dcw[15:0];
        n_s8.tl  = r_s7.tl;
    end

    // Stage 9: quadrennium estimate.
    always_comb begin
        logic [26:0] pq;
        pq = 27'(r_s8.doc) * 27'(REC_QUAD);
        n_s9.era = r_s8.era;
        n_s9.c2  = r_s8.c2;
        n_s9.q4  = pq[25:21];
        n_s9.doc = r_s8.doc;
        n_s9.tl  = r_s8.tl;
    end

    // Stage 10: remainder against the quadrennium estimate.
    always_comb begin
        logic [15:0] rw;
        rw = r_s9.doc - 16'(r_s9.q4) * 16'(QUAD_DAYS);
        n_s10.era = r_s9.era;
        n_s10.c2  = r_s9.c2;
        n_s10.q4  = r_s9.q4;
        n_s10.r4  = rw[11:0];
        n_s10.tl  = r_s9.tl;
    end

    // Stage 11: correct the quadrennium, then year within it and day of year.
    always_comb begin
        logic        ge;
        logic [11:0] dqw;
        logic [10:0] dq;
        logic [1:0]  yq;
        logic [10:0] dyw;
        logic [4:0]  q4;
        ge  = r_s10.r4 >= 12'(QUAD_DAYS);
        dqw = ge ? r_s10.r4 - 12'(QUAD_DAYS) : r_s10.r4;
        dq  = dqw[10:0];
        q4  = r_s10.q4 + 5'(ge);
        if (dq >= 11'(3 * YEAR_DAYS)) begin
            yq = 2'd3;
        end else if (dq >= 11'(2 * YEAR_DAYS)) begin
            yq = 2'd2;
        end else if (dq >= 11'(YEAR_DAYS)) begin
            yq = 2'd1;
        end else begin
            yq = 2'd0;
        end
        dyw = dq - 11'(yq) * 11'(YEAR_DAYS);
        n_s11.era = r_s10.era;
        n_s11.yoe = 9'(r_s10.c2) * 9'd100 + 9'(q4) * 9'd4 + 9'(yq);
        n_s11.doy = dyw[8:0];
        n_s11.tl  = r_s10.tl;
    end

    // Stage 12: month from the month start table, day of month, March-based year.
    always_comb begin
        int         cnt;
        logic [8:0] rdw;
        cnt = 0;
        for (int i = 1; i < 12; i++) begin
            if (r_s11.doy >= month_base(4'(i))) begin
                cnt = cnt + 1;
            end
        end
        n_s12.mp = 4'(cnt);
        rdw      = r_s11.doy - month_base(4'(cnt)) + 9'd1;
        n_s12.rd = rdw[4:0];
        n_s12.y  = 14'(r_s11.yoe) + 14'(r_s11.era) * 14'd400;
        n_s12.tl = r_s11.tl;
    end

    // Stage 13: calendar month and year, blanked when out of range.
    always_comb begin
        logic [3:0] rm;
        rm = (r_s12.mp < 4'd10) ? r_s12.mp + 4'd3 : r_s12.mp - 4'd9;
        n_out.tl = r_s12.tl;
        if (r_s12.tl.bad) begin
            n_out.yr = '0;
            n_out.mo = '0;
            n_out.dy = '0;
        end else begin
            n_out.yr = r_s12.y - 14'd400 + 14'(rm <= 4'd2);
            n_out.mo = rm;
            n_out.dy = r_s12.rd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv[0])  r_s1  <= n_s1;
        if (adv[1])  r_s2  <= n_s2;
        if (adv[2])  r_s3  <= n_s3;
        if (adv[3])  r_s4  <= n_s4;
        if (adv[4])  r_s5  <= n_s5;
        if (adv[5])  r_s6  <= n_s6;
        if (adv[6])  r_s7  <= n_s7;
        if (adv[7])  r_s8  <= n_s8;
        if (adv[8])  r_s9  <= n_s9;
        if (adv[9])  r_s10 <= n_s10;
        if (adv[10]) r_s11 <= n_s11;
        if (adv[11]) r_s12 <= n_s12;
        if (adv[12]) r_out <= n_out;
    end

    assign s_axis_tready = adv[0];
    assign m_axis_tvalid = r_v[NS-1];
    assign m_axis_tdata  = {2'b00, r_out.tl.ss, r_out.tl.mn, r_out.tl.hr, r_out.dy,
                            r_out.mo, r_out.yr, r_out.tl.shc, r_out.tl.src};
    assign m_axis_tuser  = r_out.tl.bad;

    // Input is refused only when every stage holds an item.
    a_full_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> (&r_v))
        else $error("input stalled with an empty stage");

    a_bad_blank: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v[NS-1] && r_out.tl.bad) |-> (r_out.yr == '0 && r_out.mo == '0 && r_out.dy == '0))
        else $error("out of range result carries a date");

    a_bad_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v[NS-1] && r_out.tl.bad) |->
            (r_out.tl.shc == LOW24[22:0] || r_out.tl.shc == HIGH24[22:0]))
        else $error("out of range count not at a bound");

    a_date_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v[NS-1] && !r_out.tl.bad) |->
            (r_out.mo >= 4'd1 && r_out.mo <= 4'd12 && r_out.dy >= 5'd1
             && r_out.yr <= 14'(MAX_YEAR)))
        else $error("converted date has an impossible field");

    a_time_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v[NS-1] |-> (r_out.tl.hr < 5'd24 && r_out.tl.mn < 6'd60 && r_out.tl.ss < 6'd60))
        else $error("time of day not normalised");

endmodule

// ===== test/civil_date_day_shift_tb.sv =====
// Testbench for civil_date_day_shift: drives dated time stamps with day offsets and checks
// every result against a day count predictor held in a small scoreboard class.
// Depends on cdds_pkg and the civil_date_day_shift RTL.
module civil_date_day_shift_tb;
    import cdds_pkg::*;

    localparam int RANDOM_ITEMS = 800;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 30;

    typedef struct packed {
        logic        pad;
        logic [22:0] day_offset;
        logic [5:0]  second;
        logic [5:0]  minute;
        logic [4:0]  hour;
        logic [4:0]  day;
        logic [3:0]  month;
        logic [13:0] year;
    } t_stamp;

    typedef struct packed {
        logic [1:0]  pad;
        logic [5:0]  second;
        logic [5:0]  minute;
        logic [4:0]  hour;
        logic [4:0]  day;
        logic [3:0]  month;
        logic [13:0] year;
        logic [22:0] shifted_count;
        logic [22:0] source_count;
    } t_shifted;

    typedef struct packed {
        t_shifted data;
        logic     flag;
    } t_expected;

    class day_shift_board;
        t_expected   awaited_q[$];
        int unsigned inputs_seen     = 0;
        int unsigned results_checked = 0;
        int unsigned flagged_seen    = 0;
        int unsigned errors          = 0;
        int unsigned reported        = 0;
        longint      march_start[12] = '{0, 31, 61, 92, 122, 153, 184, 214, 245, 275, 306, 337};

        // Day count of the day before the first of March of year y, for y >= -1.
        function longint days_before_year(longint y);
            longint u;
            u = y + 400;
            return 365 * u + u / 4 - u / 100 + u / 400 - ERA_DAYS;
        endfunction

        function t_expected shift_date(t_stamp s);
            longint    yr, mo, offs, secs, carry, src, sh, hi;
            longint    d, era, doe, yoe, doy, mp, y;
            t_expected e;
            e    = '0;
            yr   = longint'(s.year);
            mo   = longint'(s.month);
            offs = longint'($signed(s.day_offset));
            if (yr > MAX_YEAR) yr = MAX_YEAR;
            if (mo < 1) mo = 1;
            if (mo > 12) mo = 12;
            secs  = longint'(s.hour) * 3600 + longint'(s.minute) * 60 + longint'(s.second);
            carry = secs / 86400;
            secs  = secs % 86400;
            if (mo < 3) begin
                mo += 12;
                yr -= 1;
            end
            src = longint'(s.day) + carry + march_start[mo - 3] + days_before_year(yr);
            sh  = src + offs;
            hi  = days_before_year(MAX_YEAR) + 306;
            if (sh < LOW_COUNT) begin
                sh     = LOW_COUNT;
                e.flag = 1'b1;
            end else if (sh > hi) begin
                sh     = hi;
                e.flag = 1'b1;
            end
            if (!e.flag) begin
                d   = sh - 1 + ERA_DAYS;
                era = d / ERA_DAYS;
                doe = d % ERA_DAYS;
                yoe = (doe - doe / 1460 + doe / 36524 - doe / 146096) / 365;
                doy = doe - (365 * yoe + yoe / 4 - yoe / 100);
                mp  = (5 * doy + 2) / 153;
                y   = yoe + 400 * era;
                if (mp >= 10) y += 1;
                e.data.day   = 5'(doy - (153 * mp + 2) / 5 + 1);
                e.data.month = 4'((mp < 10) ? mp + 3 : mp - 9);
                e.data.year  = 14'(y - 400);
            end
            e.data.source_count  = src[22:0];
            e.data.shifted_count = sh[22:0];
            e.data.hour          = 5'(secs / 3600);
            e.data.minute        = 6'((secs / 60) % 60);
            e.data.second        = 6'(secs % 60);
            return e;
        endfunction

        function void note_input(t_stamp s);
            inputs_seen++;
            awaited_q.push_back(shift_date(s));
        endfunction

        function void fail(string what);
            errors++;
            if (reported < 10) begin
                reported++;
                $display("ERROR at result %0d: %s", results_checked, what);
            end
        endfunction

        function void compare_field(string name, longint unsigned want, longint unsigned got);
            if (want != got)
                fail($sformatf("%s expected %0d, got %0d", name, want, got));
        endfunction

        function void check_result(logic [87:0] tdata, logic flag);
            t_shifted  got;
            t_expected e;
            got = tdata;
            if (awaited_q.size() == 0) begin
                fail("result transfer with no input outstanding");
                return;
            end
            e = awaited_q.pop_front();
            compare_field("source_day_count", 64'(e.data.source_count), 64'(got.source_count));
            compare_field("shifted_day_count", 64'(e.data.shifted_count),
                          64'(got.shifted_count));
            compare_field("res_year", 64'(e.data.year), 64'(got.year));
            compare_field("res_month", 64'(e.data.month), 64'(got.month));
            compare_field("res_day", 64'(e.data.day), 64'(got.day));
            compare_field("res_hour", 64'(e.data.hour), 64'(got.hour));
            compare_field("res_minute", 64'(e.data.minute), 64'(got.minute));
            compare_field("res_second", 64'(e.data.second), 64'(got.second));
            compare_field("padding", 64'(0), 64'(got.pad));
            compare_field("out_of_range", 64'(e.flag), 64'(flag));
            if (flag) flagged_seen++;
            results_checked++;
        endfunction

        function int outstanding();
            return awaited_q.size();
        endfunction
    endclass

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [63:0] s_axis_tdata  = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [87:0] m_axis_tdata;
    logic [0:0]  m_axis_tuser;

    logic        burst_mode = 1'b0;
    logic        hold_req   = 1'b0;
    logic        hold_done  = 1'b0;
    int          hold_left  = 0;
    int          cycle_count = 0;

    day_shift_board board = new();

    civil_date_day_shift u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
                     board.outstanding());
            $display("simulation failed");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready) board.note_input(s_axis_tdata);
            if (m_axis_tvalid && m_axis_tready) board.check_result(m_axis_tdata, m_axis_tuser[0]);
        end
    end

    // The output side stalls at random, and once holds off long enough to fill the pipeline.
    always @(negedge i_clk) begin
        if (hold_left != 0) begin
            m_axis_tready <= 1'b0;
            hold_left     <= hold_left - 1;
            if (hold_left == 1) hold_done <= 1'b1;
        end else if (hold_req && !hold_done) begin
            m_axis_tready <= 1'b0;
            hold_left     <= HOLD_CYCLES;
        end else begin
            m_axis_tready <= burst_mode || ($urandom_range(99) >= 17);
        end
    end

    function automatic t_stamp make_stamp(int yr, int mo, int dy, int hh, int mi, int ss,
                                          int offs);
        t_stamp s;
        s.pad        = 1'b0;
        s.year       = 14'(yr);
        s.month      = 4'(mo);
        s.day        = 5'(dy);
        s.hour       = 5'(hh);
        s.minute     = 6'(mi);
        s.second     = 6'(ss);
        s.day_offset = 23'(offs);
        return s;
    endfunction

    function automatic t_stamp random_stamp();
        t_stamp s;
        int     yr;
        int     offs;
        if ($urandom_range(99) < 75) begin
            case ($urandom_range(3))
                0: yr = $urandom_range(3);
                1: yr = 9996 + $urandom_range(3);
                default: yr = $urandom_range(9999);
            endcase
            case ($urandom_range(3))
                0: offs = int'($urandom_range(800)) - 400;
                1: offs = int'($urandom_range(80000)) - 40000;
                2: offs = int'($urandom_range(7304800)) - 3652400;
                default: offs = int'($urandom);
            endcase
            s = make_stamp(yr, $urandom_range(1, 12), $urandom_range(1, 31),
                           $urandom_range(23), $urandom_range(59), $urandom_range(59), offs);
        end else begin
            s     = {$urandom, $urandom};
            s.pad = 1'b0;
        end
        return s;
    endfunction

    task automatic send_stamp(input t_stamp s);
        while (!burst_mode && $urandom_range(99) < 17) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= s;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    initial begin
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Calendar extremes and the edges of the count range.
        send_stamp(make_stamp(0, 1, 1, 0, 0, 0, 0));
        send_stamp(make_stamp(9999, 12, 31, 23, 59, 59, 0));
        send_stamp(make_stamp(0, 1, 1, 0, 0, 0, -1));
        send_stamp(make_stamp(9999, 12, 31, 23, 59, 59, 1));
        send_stamp(make_stamp(0, 3, 1, 12, 0, 0, -60));
        send_stamp(make_stamp(0, 3, 1, 12, 0, 0, -61));
        // Leap days, including the century years.
        send_stamp(make_stamp(2000, 2, 28, 6, 30, 0, 1));
        send_stamp(make_stamp(1900, 2, 28, 6, 30, 0, 1));
        send_stamp(make_stamp(2024, 2, 29, 0, 0, 1, 365));
        // Days beyond the month length and day zero normalise through the count.
        send_stamp(make_stamp(2023, 4, 31, 1, 2, 3, 0));
        send_stamp(make_stamp(2023, 2, 31, 1, 2, 3, 0));
        send_stamp(make_stamp(2023, 3, 0, 1, 2, 3, 0));
        // Month zero and months past twelve are clamped; oversized years saturate.
        send_stamp(make_stamp(1999, 0, 15, 8, 0, 0, 10));
        send_stamp(make_stamp(1999, 15, 15, 8, 0, 0, 10));
        send_stamp(make_stamp(10000, 6, 1, 8, 0, 0, -100));
        // Time fields beyond a day carry into the date.
        send_stamp(make_stamp(2010, 12, 31, 24, 0, 0, 0));
        send_stamp(make_stamp(2010, 12, 31, 31, 63, 63, 0));
        // Full-scale fields and offsets.
        send_stamp(make_stamp(16383, 15, 31, 31, 63, 63, 4194303));
        send_stamp(make_stamp(0, 0, 0, 0, 0, 0, -4194304));
        send_stamp(make_stamp(5000, 7, 4, 12, 0, 0, 3652424));
        send_stamp(make_stamp(5000, 7, 4, 12, 0, 0, -3652424));

        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            if (i == 200) hold_req <= 1'b1;
            burst_mode <= (i >= 450 && i < 600);
            send_stamp(random_stamp());
        end
        s_axis_tvalid <= 1'b0;
        burst_mode    <= 1'b0;

        while (board.outstanding() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("%0d transfers in, %0d results checked, %0d of them out of range",
                 board.inputs_seen, board.results_checked, board.flagged_seen);
        $display("output held off for %0d cycles once, %0d errors", HOLD_CYCLES, board.errors);
        if (board.errors == 0 && board.outstanding() == 0 && hold_done) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end
endmodule
